// File: src/nmpc_pkg.sv
`default_nettype none
package nmpc_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned X_W     = 11;
  localparam int unsigned Y_W     = 8;
  localparam int unsigned DIST_W  = 10;
  localparam int unsigned D2_W    = 20;
  localparam int unsigned REM_W   = 12;
  localparam int unsigned OFS_W   = 16;
  localparam int unsigned LB_W    = 8;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_MATCH = 1'b1;

  localparam logic [9:0] RED_BIAS  = 10'd512;
  localparam logic [9:0] BLUE_BIAS = 10'd767;
  localparam logic [LB_W-1:0] LINE_BYTES_RST = 8'd40;
  localparam logic [DIST_W-1:0] DIST_MAX = 10'd806;

  // Word moving along the chain: the item plus the best match so far.
  typedef struct packed {
    logic              operation;
    logic [IDX_W-1:0]  entry_index;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [X_W-1:0]    pixel_x;
    logic [Y_W-1:0]    pixel_y;
    logic [IDX_W-1:0]  best_idx;
    logic [DIST_W-1:0] best_dist;
  } word_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DIST_W-1:0] root;
  } sqrt_t;

  // One digit of a restoring integer square root.
  function automatic sqrt_t sqrt_step(sqrt_t s, logic [1:0] pair);
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    sqrt_t            o;
    cur   = {s.rem, pair};
    trial = {2'b00, s.root, 2'b01};
    if (cur >= trial) begin
      o.rem  = REM_W'(cur - trial);
      o.root = {s.root[DIST_W-2:0], 1'b1};
    end else begin
      o.rem  = REM_W'(cur);
      o.root = {s.root[DIST_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// File: src/nmpc_in_if.sv
`default_nettype none
interface nmpc_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [3:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [10:0] pixel_x;
  logic [7:0] pixel_y;
  modport source (output valid, operation, entry_index, red, green, blue, pixel_x, pixel_y,
                  input ready);
  modport sink (input valid, operation, entry_index, red, green, blue, pixel_x, pixel_y,
                output ready);
endinterface
`default_nettype wire

// File: src/nmpc_out_if.sv
`default_nettype none
interface nmpc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  color_index;
  logic        pixel_on;
  logic [15:0] byte_offset;
  logic [7:0]  bit_mask;
  logic [9:0]  min_distance;
  modport source (output valid, color_index, pixel_on, byte_offset, bit_mask, min_distance,
                  input ready);
  modport sink (input valid, color_index, pixel_on, byte_offset, bit_mask, min_distance,
                output ready);
endinterface
`default_nettype wire

// File: src/nearest_palette_color_matcher_top.sv
`default_nettype none
// An accepted pixel word passes every palette cell in turn, then the result register.
// Throughput: one word per cycle; each palette cell is a 4-stage pipe
// (squares, weighted sum, two halves of the square root) and the chain stalls
// as a whole only while the result register is held.
// Reset (rst_n, synchronous, active low) clears valid flags and sets
// line_bytes to 40; palette entries are undefined until loaded.
module nearest_palette_color_matcher_top #(
  parameter int unsigned PALETTE_ENTRIES = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data,
  nmpc_in_if.sink         in_word,
  nmpc_out_if.source      out_word
);
  import nmpc_pkg::*;

  logic [LB_W-1:0] line_bytes_r;
  logic            en;
  logic            out_vld_r;

  // chain links: link 0 is the input word
  logic  [PALETTE_ENTRIES:0] link_vld;
  word_t                     link_word [PALETTE_ENTRIES+1];
  word_t                     in_w;

  // whole chain advances unless a result sits unaccepted
  assign en            = !out_vld_r || out_word.ready;
  assign in_word.ready = en;

  always_comb begin
    in_w             = '0;
    in_w.operation   = in_word.operation;
    in_w.entry_index = in_word.entry_index;
    in_w.red         = in_word.red;
    in_w.green       = in_word.green;
    in_w.blue        = in_word.blue;
    in_w.pixel_x     = in_word.pixel_x;
    in_w.pixel_y     = in_word.pixel_y;
  end
  assign link_word[0] = in_w;
  assign link_vld[0]  = in_word.valid;

  for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
    nmpc_cell #(.CELL_IDX(k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (link_vld[k]),
      .in_word  (link_word[k]),
      .out_vld  (link_vld[k+1]),
      .out_word (link_word[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_bytes_r <= LINE_BYTES_RST;
    end else if (cfg_we) begin
      line_bytes_r <= cfg_data;
    end
  end

  // result register; load words end here without a result
  word_t           last;
  logic            out_vld_nxt;
  logic [OFS_W-1:0] ofs_nxt;
  assign last        = link_word[PALETTE_ENTRIES];
  assign out_vld_nxt = link_vld[PALETTE_ENTRIES] && last.operation == OP_MATCH;
  // row times width plus the column byte always fits in 16 bits
  assign ofs_nxt     = ({8'd0, last.pixel_y} * {8'd0, line_bytes_r}) +
                       {8'd0, last.pixel_x[10:3]};

  logic [IDX_W-1:0]  idx_r;
  logic [OFS_W-1:0]  ofs_r;
  logic [7:0]        mask_r;
  logic [DIST_W-1:0] dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r  <= last.best_idx;
      ofs_r  <= ofs_nxt;
      mask_r <= 8'h80 >> last.pixel_x[2:0];
      dist_r <= last.best_dist;
    end
  end

  assign out_word.valid        = out_vld_r;
  assign out_word.color_index  = idx_r;
  assign out_word.pixel_on     = (idx_r != '0);
  assign out_word.byte_offset  = ofs_r;
  assign out_word.bit_mask     = mask_r;
  assign out_word.min_distance = dist_r;

  a_mask_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> $onehot(mask_r)) else $error("bit mask not one-hot");
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> dist_r <= DIST_MAX) else $error("distance out of range");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> 32'(idx_r) < PALETTE_ENTRIES) else $error("index beyond palette");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(link_vld[PALETTE_ENTRIES:1])) else $error("chain moved while stalled");

endmodule
`default_nettype wire

// File: src/nmpc_cell.sv
`default_nettype none
module nmpc_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_vld,
  input  wire nmpc_pkg::word_t in_word,
  output logic                out_vld,
  output nmpc_pkg::word_t     out_word
);
  import nmpc_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [23:0] entry_r;
  logic [3:0]  vld_r, vld_nxt;
  word_t       w1_r, w2_r, w3_r, w4_r;

  logic [7:0]  rmean1_r;
  logic [15:0] drsq_r, dgsq_r, dbsq_r;
  logic [D2_W-1:0] d2_r;
  sqrt_t       sq3_r;
  logic [9:0]  lo3_r;

  // stage 1: differences and squares
  logic [7:0]  r1, g1, b1, dr, dg, db, rmean;
  always_comb begin
    r1 = entry_r[23:16];
    g1 = entry_r[15:8];
    b1 = entry_r[7:0];
    rmean = 8'(({1'b0, r1} + {1'b0, in_word.red}) >> 1);
    dr = (r1 > in_word.red)   ? r1 - in_word.red   : in_word.red - r1;
    dg = (g1 > in_word.green) ? g1 - in_word.green : in_word.green - g1;
    db = (b1 > in_word.blue)  ? b1 - in_word.blue  : in_word.blue - b1;
  end

  // stage 2: weighted sum
  logic [9:0]  wr, wb;
  logic [25:0] pr, pb;
  logic [D2_W-1:0] d2;
  always_comb begin
    wr = RED_BIAS + {2'b00, rmean1_r};
    wb = BLUE_BIAS - {2'b00, rmean1_r};
    pr = wr * drsq_r;
    pb = wb * dbsq_r;
    d2 = D2_W'(pr[25:8]) + {2'b00, dgsq_r, 2'b00} + D2_W'(pb[25:8]);
  end

  // stages 3 and 4: five root digits each
  sqrt_t sq3, sq4;
  always_comb begin
    sq3 = '0;
    for (int i = 0; i < 5; i++) begin
      sq3 = sqrt_step(sq3, d2_r[D2_W-1-2*i -: 2]);
    end
    sq4 = sq3_r;
    for (int i = 0; i < 5; i++) begin
      sq4 = sqrt_step(sq4, lo3_r[9-2*i -: 2]);
    end
  end

  word_t w4_nxt;
  always_comb begin
    w4_nxt = w3_r;
    if (CELL_IDX == 0 || sq4.root < w3_r.best_dist) begin
      w4_nxt.best_idx  = MY_IDX;
      w4_nxt.best_dist = sq4.root;
    end
  end

  assign vld_nxt = {vld_r[2:0], in_vld};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_vld && in_word.operation == OP_LOAD && in_word.entry_index == MY_IDX) begin
        entry_r <= {in_word.red, in_word.green, in_word.blue};
      end
      w1_r     <= in_word;
      rmean1_r <= rmean;
      drsq_r   <= dr * dr;
      dgsq_r   <= dg * dg;
      dbsq_r   <= db * db;
      w2_r     <= w1_r;
      d2_r     <= d2;
      w3_r     <= w2_r;
      sq3_r    <= sq3;
      lo3_r    <= d2_r[9:0];
      w4_r     <= w4_nxt;
    end
  end

  assign out_vld  = vld_r[3];
  assign out_word = w4_r;

endmodule
`default_nettype wire

// File: tb/sv/nearest_palette_color_matcher_top_tb.sv
`timescale 1ns / 1ps
module nearest_palette_color_matcher_top_tb;
  import nmpc_pkg::*;

  // Latency of the chain plus slack; loads leave no result to wait for
  localparam int unsigned SETTLE_CYCLES = 4 * 16 + 1 + 20;
  localparam int unsigned NUM_ENTRIES   = 16;

  typedef struct packed {
    logic [IDX_W-1:0]  color_index;
    logic              pixel_on;
    logic [OFS_W-1:0]  byte_offset;
    logic [7:0]        bit_mask;
    logic [DIST_W-1:0] min_distance;
  } match_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [LB_W-1:0] cfg_data = '0;

  nmpc_in_if  in_bus ();
  nmpc_out_if out_bus ();

  nearest_palette_color_matcher_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_word  (in_bus),
    .out_word (out_bus)
  );

  always #1 clk = ~clk;

  // Local copy of block state
  logic [23:0]     palette_copy [NUM_ENTRIES];
  logic [LB_W-1:0] line_bytes_copy;

  match_t pending_matches [$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;

  function automatic logic [DIST_W-1:0] floor_root(int unsigned v);
    int unsigned res;
    res = 0;
    for (int k = DIST_W - 1; k >= 0; k--) begin
      if ((res | (1 << k)) * (res | (1 << k)) <= v) res = res | (1 << k);
    end
    return DIST_W'(res);
  endfunction

  function automatic logic [DIST_W-1:0] redmean_dist(logic [23:0] ent,
                                                    logic [7:0] r, logic [7:0] g,
                                                    logic [7:0] b);
    int unsigned r1, g1, b1, rmean, dr, dg, db, d2;
    r1 = ent[23:16];
    g1 = ent[15:8];
    b1 = ent[7:0];
    rmean = (r1 + r) >> 1;
    dr = (r1 > r) ? r1 - r : r - r1;
    dg = (g1 > g) ? g1 - g : g - g1;
    db = (b1 > b) ? b1 - b : b - b1;
    d2 = (((512 + rmean) * dr * dr) >> 8) + 4 * dg * dg + (((767 - rmean) * db * db) >> 8);
    return floor_root(d2);
  endfunction

  // Nearest entry; strict less-than keeps the lowest index on a tie
  function automatic match_t nearest_match(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                           logic [X_W-1:0] x, logic [Y_W-1:0] y);
    match_t m;
    int unsigned best, d, bi;
    best = 9999;
    bi = 0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      d = redmean_dist(palette_copy[i], r, g, b);
      if (d < best) begin
        best = d;
        bi = i;
      end
    end
    m.color_index  = IDX_W'(bi);
    m.pixel_on     = (bi != 0);
    m.byte_offset  = OFS_W'(32'(y) * 32'(line_bytes_copy) + 32'(x >> 3));
    m.bit_mask     = 8'(1 << (7 - x[2:0]));
    m.min_distance = DIST_W'(best);
    return m;
  endfunction

  // Presents one word from a falling edge; returns just after its acceptance edge
  task automatic send_word(logic op, logic [3:0] idx, logic [7:0] r, logic [7:0] g,
                           logic [7:0] b, logic [X_W-1:0] x, logic [Y_W-1:0] y);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid       = 1'b1;
    in_bus.operation   = op;
    in_bus.entry_index = idx;
    in_bus.red         = r;
    in_bus.green       = g;
    in_bus.blue        = b;
    in_bus.pixel_x     = x;
    in_bus.pixel_y     = y;
    do @(posedge clk); while (!in_bus.ready);
    if (op == OP_LOAD) palette_copy[idx] = {r, g, b};
    else pending_matches.push_back(nearest_match(r, g, b, x, y));
  endtask

  task automatic load_entry(logic [3:0] idx, logic [23:0] rgb);
    send_word(OP_LOAD, idx, rgb[23:16], rgb[15:8], rgb[7:0], X_W'($urandom), Y_W'($urandom));
  endtask

  task automatic send_pixel(logic [23:0] rgb, logic [X_W-1:0] x, logic [Y_W-1:0] y);
    send_word(OP_MATCH, 4'($urandom), rgb[23:16], rgb[15:8], rgb[7:0], x, y);
  endtask

  // Block idle: nothing owed and the chain flushed of loads
  task automatic drain;
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_line_bytes(logic [LB_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    line_bytes_copy = v;
  endtask

  // Result checker: oldest expectation against each accepted word
  always @(posedge clk) begin
    match_t got, want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = {out_bus.color_index, out_bus.pixel_on, out_bus.byte_offset,
             out_bus.bit_mask, out_bus.min_distance};
      if (pending_matches.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result word %p", got);
      end else begin
        want = pending_matches.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // Receiver stalls
  always @(negedge clk) out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);

  // Full palette with extremes and a duplicate pair for the tie rule
  task automatic test_directed;
    logic [23:0] dir_pal [NUM_ENTRIES];
    dir_pal = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                24'h808080, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h808080,
                24'h400000, 24'h004000, 24'h000040, 24'hC0C0C0, 24'h123456, 24'hFEDCBA};
    for (int i = 0; i < NUM_ENTRIES; i++) load_entry(4'(i), dir_pal[i]);
    send_pixel(24'h000000, 11'd0, 8'd0);       // entry 0: pixel off
    send_pixel(24'hFFFFFF, 11'd2047, 8'd255);
    send_pixel(24'h808080, 11'd7, 8'd1);       // tie, lower index wins
    send_pixel(24'h818181, 11'd8, 8'd128);
    send_pixel(24'hFF0000, 11'd1, 8'd255);
    send_pixel(24'h0000FF, 11'd1023, 8'd0);
    send_pixel(24'h7F007F, 11'd3, 8'd77);
    send_pixel(24'hFF00FF, 11'd2040, 8'd254);  // column beyond row
  endtask

  // Line width extremes including zero
  task automatic test_line_bytes;
    logic [LB_W-1:0] widths [4];
    widths = '{8'd0, 8'd1, 8'd255, 8'($urandom)};
    foreach (widths[w]) begin
      write_line_bytes(widths[w]);
      send_pixel(24'($urandom), 11'd2047, 8'd255);
      send_pixel(24'($urandom), 11'd0, 8'd255);
      send_pixel(24'($urandom), 11'($urandom), 8'($urandom));
    end
  endtask

  // Mostly pixels with a scattering of palette reloads
  task automatic test_random(int unsigned count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) == 0) load_entry(4'($urandom), 24'($urandom));
      else send_pixel(24'($urandom), 11'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    in_bus.valid       = 1'b0;
    in_bus.operation   = OP_LOAD;
    in_bus.entry_index = '0;
    in_bus.red         = '0;
    in_bus.green       = '0;
    in_bus.blue        = '0;
    in_bus.pixel_x     = '0;
    in_bus.pixel_y     = '0;
    out_bus.ready      = 1'b0;
    line_bytes_copy    = LINE_BYTES_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 25;
    recv_idle_pct = 49;
    test_directed();
    test_line_bytes();
    write_line_bytes(8'd40);
    test_random(220);
    send_idle_pct = 49;
    recv_idle_pct = 25;
    write_line_bytes(8'd255);
    test_random(220);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_line_bytes(8'd1);
    test_random(210);
    drain();

    if (mismatch_count == 0 && pending_matches.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
